FILE: hdl/jsu_pkg.sv
// shared types and codes for the json string unescape block
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

	localparam int QueueDepth = 4;
	localparam int QueueAw = $clog2(QueueDepth);

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_CTRL    = 3'd1;
	localparam logic [2:0] ERR_ESCAPE  = 3'd2;
	localparam logic [2:0] ERR_HEX     = 3'd3;
	localparam logic [2:0] ERR_SURR    = 3'd4;
	localparam logic [2:0] ERR_UNTERM  = 3'd5;

	// at most one command per input byte: up to four utf-8 bytes and an optional end result
	typedef struct packed {
		logic [2:0]       nbytes;
		logic [3:0][7:0]  bytes;
		logic             has_end;
		logic [2:0]       err;
	} cmd_t;

endpackage
`default_nettype wire

FILE: hdl/jsu_front.sv
// front end: escape and surrogate decoder, one raw byte per cycle while the queue is not full
`timescale 1ns / 1ps
`default_nettype none
module jsu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          first_byte,
	input  wire logic          buffer_end,
	input  wire logic          q_full,
	output logic               push,
	output jsu_pkg::cmd_t      push_cmd
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_PLAIN  = 3'd1;
	localparam logic [2:0] PH_ESC    = 3'd2;
	localparam logic [2:0] PH_HEX    = 3'd3;
	localparam logic [2:0] PH_LOWBS  = 3'd4;
	localparam logic [2:0] PH_LOWU   = 3'd5;
	localparam logic [2:0] PH_LOWHEX = 3'd6;

	logic [2:0]  phase_q, nxt_phase, ph;
	logic [15:0] acc_q, nxt_acc, acc_new;
	logic [9:0]  high_q, nxt_high;
	logic [1:0]  cnt_q, nxt_cnt;
	logic [4:0]  hx;
	logic [20:0] cp;
	logic        do_enc;
	logic        take;
	jsu_pkg::cmd_t cmd_d;

	// bit 4 set for a valid hex digit, low bits hold its value
	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]})
			r = {1'b1, c[3:0]};
		else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

	assign in_ready = !q_full;
	assign take = in_valid && in_ready;

	always_comb begin
		ph = first_byte ? PH_PLAIN : phase_q;
		nxt_phase = ph;
		nxt_acc = acc_q;
		nxt_high = high_q;
		nxt_cnt = cnt_q;
		cmd_d = '0;
		cp = '0;
		do_enc = 1'b0;
		hx = hexval(in_byte);
		acc_new = {acc_q[11:0], hx[3:0]};
		case (ph)
			PH_PLAIN: begin
				if (in_byte < 8'h20) begin
					cmd_d.has_end = 1'b1;
					cmd_d.err = jsu_pkg::ERR_CTRL;
					nxt_phase = PH_IDLE;
				end else if (in_byte == 8'h22) begin
					cmd_d.has_end = 1'b1;
					nxt_phase = PH_IDLE;
				end else if (in_byte == 8'h5c) begin
					nxt_phase = PH_ESC;
				end else begin
					cmd_d.nbytes = 3'd1;
					cmd_d.bytes[0] = in_byte;
				end
			end
			PH_ESC: begin
				nxt_phase = PH_PLAIN;
				cmd_d.nbytes = 3'd1;
				case (in_byte)
					8'h22, 8'h5c, 8'h2f: cmd_d.bytes[0] = in_byte;
					8'h62: cmd_d.bytes[0] = 8'h08;
					8'h66: cmd_d.bytes[0] = 8'h0c;
					8'h6e: cmd_d.bytes[0] = 8'h0a;
					8'h72: cmd_d.bytes[0] = 8'h0d;
					8'h74: cmd_d.bytes[0] = 8'h09;
					8'h75: begin
						cmd_d.nbytes = 3'd0;
						nxt_phase = PH_HEX;
						nxt_acc = '0;
						nxt_cnt = '0;
					end
					default: begin
						cmd_d.nbytes = 3'd0;
						cmd_d.has_end = 1'b1;
						cmd_d.err = jsu_pkg::ERR_ESCAPE;
						nxt_phase = PH_IDLE;
					end
				endcase
			end
			PH_HEX, PH_LOWHEX: begin
				if (in_byte < 8'h20) begin
					cmd_d.has_end = 1'b1;
					cmd_d.err = jsu_pkg::ERR_CTRL;
					nxt_phase = PH_IDLE;
				end else if (!hx[4]) begin
					cmd_d.has_end = 1'b1;
					cmd_d.err = jsu_pkg::ERR_HEX;
					nxt_phase = PH_IDLE;
				end else begin
					nxt_acc = acc_new;
					if (cnt_q != 2'd3) begin
						nxt_cnt = 2'(cnt_q + 2'd1);
					end else begin
						nxt_cnt = '0;
						if (ph == PH_HEX) begin
							if (acc_new inside {[16'hd800:16'hdbff]}) begin
								nxt_high = acc_new[9:0];
								nxt_phase = PH_LOWBS;
							end else begin
								cp = {5'd0, acc_new};
								do_enc = 1'b1;
							end
						end else if (!(acc_new inside {[16'hdc00:16'hdfff]})) begin
							cmd_d.has_end = 1'b1;
							cmd_d.err = jsu_pkg::ERR_SURR;
							nxt_phase = PH_IDLE;
						end else begin
							cp = {11'(11'(high_q) + 11'h040), acc_new[9:0]};
							do_enc = 1'b1;
						end
					end
				end
			end
			PH_LOWBS, PH_LOWU: begin
				if (in_byte < 8'h20) begin
					cmd_d.has_end = 1'b1;
					cmd_d.err = jsu_pkg::ERR_CTRL;
					nxt_phase = PH_IDLE;
				end else if (ph == PH_LOWBS && in_byte == 8'h5c) begin
					nxt_phase = PH_LOWU;
				end else if (ph == PH_LOWU && in_byte == 8'h75) begin
					nxt_phase = PH_LOWHEX;
					nxt_acc = '0;
					nxt_cnt = '0;
				end else begin
					cmd_d.has_end = 1'b1;
					cmd_d.err = jsu_pkg::ERR_SURR;
					nxt_phase = PH_IDLE;
				end
			end
			default: nxt_phase = PH_IDLE;
		endcase

		if (do_enc) begin
			if (cp == 21'd0 || cp inside {[21'h00d800:21'h00dfff]}) begin
				cmd_d.has_end = 1'b1;
				cmd_d.err = jsu_pkg::ERR_SURR;
				nxt_phase = PH_IDLE;
			end else begin
				nxt_phase = PH_PLAIN;
				if (cp < 21'h80) begin
					cmd_d.nbytes = 3'd1;
					cmd_d.bytes[0] = cp[7:0];
				end else if (cp < 21'h800) begin
					cmd_d.nbytes = 3'd2;
					cmd_d.bytes[0] = {3'b110, cp[10:6]};
					cmd_d.bytes[1] = {2'b10, cp[5:0]};
				end else if (cp < 21'h10000) begin
					cmd_d.nbytes = 3'd3;
					cmd_d.bytes[0] = {4'b1110, cp[15:12]};
					cmd_d.bytes[1] = {2'b10, cp[11:6]};
					cmd_d.bytes[2] = {2'b10, cp[5:0]};
				end else begin
					cmd_d.nbytes = 3'd4;
					cmd_d.bytes[0] = {5'b11110, cp[20:18]};
					cmd_d.bytes[1] = {2'b10, cp[17:12]};
					cmd_d.bytes[2] = {2'b10, cp[11:6]};
					cmd_d.bytes[3] = {2'b10, cp[5:0]};
				end
			end
		end

		if (buffer_end && nxt_phase != PH_IDLE) begin
			cmd_d.has_end = 1'b1;
			cmd_d.err = jsu_pkg::ERR_UNTERM;
			nxt_phase = PH_IDLE;
		end
	end

	assign push = take && (cmd_d.nbytes != 3'd0 || cmd_d.has_end);
	assign push_cmd = cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= '0;
			high_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			phase_q <= nxt_phase;
			acc_q <= nxt_acc;
			high_q <= nxt_high;
			cnt_q <= nxt_cnt;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/jsu_queue.sv
// command queue between decoder and result sequencer
`timescale 1ns / 1ps
`default_nettype none
module jsu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire jsu_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output jsu_pkg::cmd_t      head_cmd
);

	jsu_pkg::cmd_t mem_q [jsu_pkg::QueueDepth];
	logic [jsu_pkg::QueueAw-1:0] wr_q, rd_q;
	logic [jsu_pkg::QueueAw:0]   cnt_q;

	assign full = (cnt_q == (jsu_pkg::QueueAw + 1)'(jsu_pkg::QueueDepth));
	assign head_valid = (cnt_q != '0);
	assign head_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + (jsu_pkg::QueueAw)'(1);
			if (pop)
				rd_q <= rd_q + (jsu_pkg::QueueAw)'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (jsu_pkg::QueueAw + 1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (jsu_pkg::QueueAw + 1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");

endmodule
`default_nettype wire

FILE: hdl/jsu_back.sv
// back end: expands each command into result transactions, one per cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none
module jsu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire jsu_pkg::cmd_t head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               string_done,
	output logic [2:0]         error_code,
	output logic               run_last
);

	jsu_pkg::cmd_t cur_q;
	logic          cur_valid_q;
	logic [2:0]    idx_q;
	logic [2:0]    total;
	logic          is_byte;
	logic          advance;
	logic          load;

	assign total = 3'(cur_q.nbytes + 3'(cur_q.has_end));
	assign is_byte = (idx_q < cur_q.nbytes);

	assign out_valid = cur_valid_q;
	assign out_byte = is_byte ? cur_q.bytes[idx_q[1:0]] : 8'h00;
	assign byte_valid = is_byte;
	assign string_done = !is_byte;
	assign error_code = is_byte ? jsu_pkg::ERR_NONE : cur_q.err;
	assign run_last = (idx_q == 3'(total - 3'd1));

	assign advance = out_valid && out_ready;
	assign load = !cur_valid_q || (advance && run_last);
	assign pop = load && head_valid;

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			cur_valid_q <= head_valid;
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(idx_q))
		else $error("result index moved during stall");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> run_last)
		else $error("string end not the last result of its byte");

endmodule
`default_nettype wire

FILE: hdl/json_string_unescape_utf8.sv
// top level of the json string unescape to utf-8 decoder
//
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   in_byte, first_byte, buffer_end
// out      out  out_valid / out_ready out_byte, byte_valid, string_done, error_code, run_last
//
// the decoder takes one raw byte per cycle while the four-entry command queue has room
// the result sequencer gives one result per cycle while out_ready is high, all results of a byte in turn
// a multi-byte utf-8 code point therefore stalls input only after the queue fills
// arst_n clears decoder phase, queue pointers and sequencer; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        first_byte,
	input  wire logic        buffer_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             string_done,
	output logic [2:0]       error_code,
	output logic             run_last
);

	logic          push, full, pop, head_valid;
	jsu_pkg::cmd_t push_cmd, head_cmd;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.first_byte (first_byte),
		.buffer_end (buffer_end),
		.q_full     (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	jsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.string_done (string_done),
		.error_code  (error_code),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the json string unescape to utf-8 decoder
`timescale 1ns / 1ps
module tb_top;

	localparam int RANDOM_ITEMS = 380;
	localparam int QUIET_LEFT = 40;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AT = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int TIMEOUT_NS = 5_000_000;

	localparam logic [7:0] QUOTE = 8'h22;
	localparam logic [7:0] BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_PLAIN  = 4'd1;
	localparam logic [3:0] ST_ESC    = 4'd2;
	localparam logic [3:0] ST_HEX    = 4'd3;
	localparam logic [3:0] ST_LOWBS  = 4'd4;
	localparam logic [3:0] ST_LOWU   = 4'd5;
	localparam logic [3:0] ST_LOWHEX = 4'd6;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       bend;
		logic       pause;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic [2:0] err;
		logic       last;
	} utf8_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       buffer_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_done;
	logic [2:0] error_code;
	logic       run_last;

	raw_byte_t    raw_q[$];
	utf8_result_t utf8_q[$];
	logic [7:0]   str_q[$];
	raw_byte_t    next_raw;

	logic [3:0]  dec_st = ST_IDLE;
	logic [15:0] hex_acc = '0;
	logic [9:0]  hi_bits = '0;
	logic [1:0]  hex_cnt = '0;
	int          emitted;

	int gap_cnt = 0;
	int stall_cnt = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	int bytes_in = 0;
	int results_seen = 0;
	int strings_ended = 0;
	int strings_failed = 0;
	int pauses = 0;
	int mismatches = 0;

	logic [7:0] esc_letters [0:7] = '{QUOTE, BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	json_string_unescape_utf8 uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.first_byte(first_byte),
		.buffer_end(buffer_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.string_done(string_done),
		.error_code(error_code),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	task automatic push_result(input logic [7:0] d, input logic v, input logic dn,
			input logic [2:0] e);
		utf8_result_t r;
		r.data = d;
		r.valid = v;
		r.done = dn;
		r.err = e;
		r.last = 1'b0;
		utf8_q.push_back(r);
		emitted++;
	endtask

	task automatic abort_string(input logic [2:0] e);
		dec_st = ST_IDLE;
		push_result(8'h00, 1'b0, 1'b1, e);
	endtask

	task automatic emit_code_point(input logic [20:0] cp);
		if (cp == 21'd0 || cp > 21'h10ffff || (cp >= 21'h00d800 && cp <= 21'h00dfff)) begin
			abort_string(jsu_pkg::ERR_SURR);
		end else begin
			if (cp < 21'h80) begin
				push_result(cp[7:0], 1'b1, 1'b0, jsu_pkg::ERR_NONE);
			end else if (cp < 21'h800) begin
				push_result({3'b110, cp[10:6]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				push_result({2'b10, cp[5:0]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
			end else if (cp < 21'h10000) begin
				push_result({4'b1110, cp[15:12]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				push_result({2'b10, cp[11:6]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				push_result({2'b10, cp[5:0]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
			end else begin
				push_result({5'b11110, cp[20:18]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				push_result({2'b10, cp[17:12]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				push_result({2'b10, cp[11:6]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				push_result({2'b10, cp[5:0]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
			end
			dec_st = ST_PLAIN;
		end
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic first, input logic bend);
		int digit;
		utf8_result_t r;
		emitted = 0;
		if (first) begin
			dec_st = ST_PLAIN;
			hex_acc = '0;
			hi_bits = '0;
			hex_cnt = '0;
		end
		case (dec_st)
			ST_PLAIN: begin
				if (c < CTRL_LIMIT) begin
					abort_string(jsu_pkg::ERR_CTRL);
				end else if (c == QUOTE) begin
					dec_st = ST_IDLE;
					push_result(8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE);
				end else if (c == BSLASH) begin
					dec_st = ST_ESC;
				end else begin
					push_result(c, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
				end
			end
			ST_ESC: begin
				dec_st = ST_PLAIN;
				case (c)
					QUOTE, BSLASH, CH_SLASH: push_result(c, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
					CH_B: push_result(8'h08, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
					CH_F: push_result(8'h0c, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
					CH_N: push_result(8'h0a, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
					CH_R: push_result(8'h0d, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
					CH_T: push_result(8'h09, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
					CH_U: begin
						dec_st = ST_HEX;
						hex_acc = '0;
						hex_cnt = '0;
					end
					default: abort_string(jsu_pkg::ERR_ESCAPE);
				endcase
			end
			ST_HEX, ST_LOWHEX: begin
				if (c >= 8'h30 && c <= 8'h39) digit = int'(c) - 'h30;
				else if (c >= 8'h61 && c <= 8'h66) digit = int'(c) - 'h61 + 10;
				else if (c >= 8'h41 && c <= 8'h46) digit = int'(c) - 'h41 + 10;
				else digit = -1;
				if (c < CTRL_LIMIT) begin
					abort_string(jsu_pkg::ERR_CTRL);
				end else if (digit < 0) begin
					abort_string(jsu_pkg::ERR_HEX);
				end else begin
					hex_acc = {hex_acc[11:0], 4'(digit)};
					if (hex_cnt < 2'd3) begin
						hex_cnt = hex_cnt + 2'd1;
					end else begin
						hex_cnt = '0;
						if (dec_st == ST_HEX) begin
							if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
								hi_bits = hex_acc[9:0];
								dec_st = ST_LOWBS;
							end else begin
								emit_code_point({5'd0, hex_acc});
							end
						end else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
							abort_string(jsu_pkg::ERR_SURR);
						end else begin
							emit_code_point(21'h10000 + {1'b0, hi_bits, hex_acc[9:0]});
						end
					end
				end
			end
			ST_LOWBS: begin
				if (c < CTRL_LIMIT) abort_string(jsu_pkg::ERR_CTRL);
				else if (c != BSLASH) abort_string(jsu_pkg::ERR_SURR);
				else dec_st = ST_LOWU;
			end
			ST_LOWU: begin
				if (c < CTRL_LIMIT) begin
					abort_string(jsu_pkg::ERR_CTRL);
				end else if (c != CH_U) begin
					abort_string(jsu_pkg::ERR_SURR);
				end else begin
					dec_st = ST_LOWHEX;
					hex_acc = '0;
					hex_cnt = '0;
				end
			end
			default: dec_st = ST_IDLE;
		endcase
		if (bend && dec_st != ST_IDLE) abort_string(jsu_pkg::ERR_UNTERM);
		if (emitted > 0) begin
			r = utf8_q.pop_back();
			r.last = 1'b1;
			utf8_q.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		utf8_result_t want;
		results_seen++;
		if (string_done) begin
			strings_ended++;
			if (error_code != jsu_pkg::ERR_NONE) strings_failed++;
		end
		if (utf8_q.size() == 0) begin
			$display("%0t: unexpected transaction, expected none, actual byte %0h done %0b err %0d",
				$time, out_byte, string_done, error_code);
			mismatches++;
		end else begin
			want = utf8_q.pop_front();
			check_field("out_byte", want.data, out_byte);
			check_field("byte_valid", 8'(want.valid), 8'(byte_valid));
			check_field("string_done", 8'(want.done), 8'(string_done));
			check_field("error_code", 8'(want.err), 8'(error_code));
			check_field("run_last", 8'(want.last), 8'(run_last));
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			first_byte <= 1'b0;
			buffer_end <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				decode_byte(in_byte, first_byte, buffer_end);
				bytes_in++;
			end
			if (gap_cnt > 0) begin
				gap_cnt--;
				in_valid <= 1'b0;
			end else if (raw_q.size() == 0 || (raw_q[0].pause && utf8_q.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				next_raw = raw_q.pop_front();
				if (next_raw.pause) pauses++;
				in_valid <= 1'b1;
				in_byte <= next_raw.data;
				first_byte <= next_raw.first;
				buffer_end <= next_raw.bend;
				if (raw_q.size() >= QUIET_LEFT && $urandom_range(0, 7) == 0)
					gap_cnt = $urandom_range(1, 18);
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) check_result();
			if (!hold_done && bytes_in >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (raw_q.size() < QUIET_LEFT) begin
				out_ready <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0) stall_cnt = $urandom_range(1, 18);
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) c = 8'h30 + {4'd0, v};
		else if ($urandom_range(0, 1) == 1) c = 8'h57 + {4'd0, v};
		else c = 8'h37 + {4'd0, v};
		return c;
	endfunction

	task automatic add_u(input logic [15:0] v);
		str_q.push_back(BSLASH);
		str_q.push_back(CH_U);
		for (int i = 3; i >= 0; i--) str_q.push_back(hex_char(v[i*4 +: 4]));
	endtask

	task automatic add_raw(input logic [7:0] d, input logic first, input logic bend,
			input logic pause);
		raw_byte_t r;
		r.data = d;
		r.first = first;
		r.bend = bend;
		r.pause = pause;
		raw_q.push_back(r);
	endtask

	task automatic flush_string(input logic bend_last, input logic pause);
		int last;
		last = str_q.size() - 1;
		for (int i = 0; i <= last; i++)
			add_raw(str_q[i], i == 0, (i == last && bend_last) || $urandom_range(0, 63) == 0,
				i == 0 && pause);
		str_q.delete();
	endtask

	task automatic add_token(input bit broken);
		int kind;
		logic [7:0] c;
		logic [15:0] cp;
		kind = $urandom_range(0, broken ? 9 : 7);
		case (kind)
			4: begin
				str_q.push_back(BSLASH);
				str_q.push_back(esc_letters[$urandom_range(0, 7)]);
			end
			5: begin
				case ($urandom_range(0, 3))
					0: cp = 16'($urandom_range(1, 'h7f));
					1: cp = 16'($urandom_range('h80, 'h7ff));
					2: cp = 16'($urandom_range('h800, 'hd7ff));
					default: cp = 16'($urandom_range('he000, 'hffff));
				endcase
				add_u(cp);
			end
			6, 7: begin
				add_u(16'hd800 + 16'($urandom_range(0, 1023)));
				add_u(16'hdc00 + 16'($urandom_range(0, 1023)));
			end
			8: begin
				case ($urandom_range(0, 4))
					0: add_u(16'h0000);
					1: add_u(16'hdc00 + 16'($urandom_range(0, 1023)));
					2: begin
						add_u(16'hd800 + 16'($urandom_range(0, 1023)));
						add_u($urandom_range(0, 1) == 1 ? 16'($urandom_range(0, 'hdbff))
							: 16'($urandom_range('he000, 'hffff)));
					end
					3: begin
						add_u(16'hd800 + 16'($urandom_range(0, 1023)));
						str_q.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						add_u(16'hd800 + 16'($urandom_range(0, 1023)));
						str_q.push_back(BSLASH);
						str_q.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end
			9: begin
				if ($urandom_range(0, 1) == 1) begin
					str_q.push_back(BSLASH);
					str_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					str_q.push_back(8'($urandom_range(0, 31)));
				end
			end
			default: begin
				do c = 8'($urandom_range('h20, 'hff));
				while (c == QUOTE || c == BSLASH);
				str_q.push_back(c);
			end
		endcase
	endtask

	task automatic build_stimulus();
		int nstr;
		int ntok;
		int ending;
		bit broken;
		// directed: idle byte, max code point pair, control byte, control at escape
		add_raw(8'h61, 1'b0, 1'b0, 1'b0);
		add_u(16'hdbff);
		add_u(16'hdfff);
		str_q.push_back(QUOTE);
		flush_string(1'b0, 1'b0);
		add_raw(8'h1f, 1'b1, 1'b0, 1'b0);
		add_raw(BSLASH, 1'b1, 1'b0, 1'b0);
		add_raw(8'h00, 1'b0, 1'b0, 1'b0);
		// top byte passthrough, then unterminated at buffer end
		add_raw(8'hff, 1'b1, 1'b0, 1'b0);
		add_raw(8'h20, 1'b0, 1'b1, 1'b0);
		// restart of an open string, then an empty string
		add_raw(8'h62, 1'b1, 1'b0, 1'b0);
		add_raw(QUOTE, 1'b1, 1'b0, 1'b0);
		nstr = 0;
		while (raw_q.size() < RANDOM_ITEMS) begin
			broken = $urandom_range(0, 3) == 0;
			ntok = $urandom_range(0, 8);
			for (int k = 0; k < ntok; k++) add_token(broken && $urandom_range(0, 2) == 0);
			if (broken && str_q.size() > 0 && $urandom_range(0, 1) == 1)
				str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom_range(0, 255));
			ending = $urandom_range(0, 9);
			if (ending >= 2) str_q.push_back(QUOTE);
			flush_string(ending == 0, nstr % 12 == 6);
			nstr++;
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2)) add_raw(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
		end
	endtask

	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (raw_q.size() != 0 || in_valid || utf8_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d input bytes and %0d results; %0d strings ended, %0d of them by error",
			bytes_in, results_seen, strings_ended, strings_failed);
		$display("output held off %0d cycles once; input drained to empty %0d times",
			LONG_HOLD, pauses);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d results still outstanding", $time, utf8_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
